[rtl/core/cbl_pkg.sv]
// ----------------------------------------------------------------------------
// cbl_pkg: shared types and constants of the charge bar lamp scan driver
// Display modes, register indexes, lamp scan order and bar decoding.
// ----------------------------------------------------------------------------
package cbl_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned SocW    = 3;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned LampN   = 6;
  localparam int unsigned BarN    = 4;
  localparam int unsigned StepW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CodeW-1:0] NoLamp   = 3'd6;
  localparam logic [CodeW-1:0] ScanLast = 3'd5;
  localparam logic [SocW-1:0]  SocFull  = 3'd4;
  localparam logic [StepW-1:0] StepFull = 3'd4;

  localparam logic [PeriodW-1:0] BlinkReset = 16'd200;
  localparam logic [PeriodW-1:0] AnimReset  = 16'd400;

  typedef enum logic [ModeW-1:0] {
    MODE_DIS        = 3'd0,
    MODE_AUTO_DIS   = 3'd1,
    MODE_ERR        = 3'd2,
    MODE_FULL       = 3'd3,
    MODE_CHARGE     = 3'd4,
    MODE_CHARGE_ERR = 3'd5,
    MODE_OFF        = 3'd6,
    MODE_HOLD       = 3'd7
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLINK_PERIOD = 2'd0,
    REG_ANIM_PERIOD  = 2'd1
  } reg_idx_e;

  typedef logic [LampN-1:0] lamps_t;

  function automatic logic [2:0] scan_lamp(input logic [CodeW-1:0] idx);
    logic [2:0] lamp;
    case (idx)
      3'd0:    lamp = 3'd3;
      3'd1:    lamp = 3'd2;
      3'd2:    lamp = 3'd1;
      3'd3:    lamp = 3'd0;
      3'd4:    lamp = 3'd4;
      default: lamp = 3'd5;
    endcase
    return lamp;
  endfunction

  function automatic logic [BarN-1:0] bar_bits(input logic [SocW-1:0] n);
    logic [BarN-1:0] b;
    for (int k = 0; k < BarN; k++) begin
      b[k] = (n > SocW'(k));
    end
    return b;
  endfunction

endpackage

[rtl/core/cbl_intf.sv]
// ----------------------------------------------------------------------------
// cbl_intf: handshake channels of the charge bar lamp scan driver
// Tick item channel, result item channel and register write channel.
// ----------------------------------------------------------------------------
interface cbl_in_if;
  logic                     valid;
  logic                     ready;
  logic [cbl_pkg::ModeW-1:0] mode;
  logic [cbl_pkg::SocW-1:0]  state_of_charge;

  modport source (output valid, mode, state_of_charge, input ready);
  modport sink   (input valid, mode, state_of_charge, output ready);
endinterface

interface cbl_out_if;
  logic                      valid;
  logic                      ready;
  logic [cbl_pkg::CodeW-1:0] select_code;
  logic [cbl_pkg::LampN-1:0] lamp_states;

  modport source (output valid, select_code, lamp_states, input ready);
  modport sink   (input valid, select_code, lamp_states, output ready);
endinterface

interface cbl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbl_pkg::CfgIdxW-1:0] index;
  logic [cbl_pkg::PeriodW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/charge_bar_led_scan_driver.sv]
// ----------------------------------------------------------------------------
// charge_bar_led_scan_driver: charge bar lamp update and multiplexed scan
// Path: an accepted tick item is held in the input register, then its result
// item in the result register. Throughput: one item per cycle while the result
// side is ready; input register, one update stage, result register.
// Reset: lamps, counters, previous mode and scan index clear; periods load
// 200 and 400 ticks.
// ----------------------------------------------------------------------------
module charge_bar_led_scan_driver (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbl_cfg_if.sink   cfg_i,
  cbl_in_if.sink    item_i,
  cbl_out_if.source result_o
);
  import cbl_pkg::*;

  logic [PeriodW-1:0] blink_q, anim_period_q;

  logic               in_valid_q;
  mode_e              mode_q;
  logic [SocW-1:0]    soc_q;

  lamps_t             lamps_q, lamps_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic [StepW-1:0]   step_q, step_d;
  mode_e              prev_mode_q;
  logic [CodeW-1:0]   scan_q, scan_d;

  logic               out_valid_q;
  logic [CodeW-1:0]   code_q, code_d;

  logic               advance;
  logic [PeriodW-1:0] period;
  logic               hit;
  logic [PeriodW-1:0] tick_run;
  logic [BarN-1:0]    bar;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q       <= BlinkReset;
      anim_period_q <= AnimReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLINK_PERIOD: blink_q       <= cfg_i.data;
        REG_ANIM_PERIOD:  anim_period_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      mode_q <= mode_e'(item_i.mode);
      soc_q  <= item_i.state_of_charge;
    end
  end

  assign period   = (mode_q == MODE_CHARGE) ? anim_period_q : blink_q;
  assign hit      = !(tick_q < period);
  assign tick_run = hit ? '0 : tick_q + PeriodW'(1);

  always_comb begin
    lamps_d = lamps_q;
    tick_d  = tick_q;
    step_d  = step_q;
    bar     = lamps_q[BarN-1:0];
    unique case (mode_q)
      MODE_DIS: begin
        lamps_d = {2'b11, bar_bits(soc_q)};
      end
      MODE_AUTO_DIS: begin
        tick_d  = tick_run;
        lamps_d = {1'b0, lamps_q[4] ^ hit, bar_bits(soc_q)};
      end
      MODE_ERR: begin
        lamps_d = 6'b100000;
      end
      MODE_FULL: begin
        lamps_d = 6'b011111;
      end
      MODE_CHARGE: begin
        tick_d = tick_run;
        if (hit) begin
          if (soc_q <= SocFull) begin
            step_d = (step_q < soc_q) ? step_q + StepW'(1) : '0;
          end else begin
            step_d = StepFull;
          end
          bar = bar_bits(step_d);
        end
        lamps_d = {2'b01, bar};
      end
      MODE_CHARGE_ERR: begin
        tick_d  = tick_run;
        lamps_d = {lamps_q[5] ^ hit, 5'b00000};
      end
      MODE_OFF: begin
        lamps_d = '0;
      end
      MODE_HOLD: ;
    endcase
    if (mode_q != prev_mode_q) begin
      tick_d = '0;
    end
  end

  always_comb begin
    if (scan_q > ScanLast) begin
      code_d = NoLamp;
      scan_d = '0;
    end else begin
      code_d = lamps_d[scan_lamp(scan_q)] ? scan_q : NoLamp;
      scan_d = (scan_q == ScanLast) ? '0 : scan_q + CodeW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamps_q     <= '0;
      tick_q      <= '0;
      step_q      <= '0;
      prev_mode_q <= MODE_DIS;
      scan_q      <= '0;
    end else if (advance) begin
      lamps_q     <= lamps_d;
      tick_q      <= tick_d;
      step_q      <= step_d;
      prev_mode_q <= mode_q;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.select_code = code_q;
  assign result_o.lamp_states = lamps_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= ScanLast)
    else $error("scan index beyond last lamp");

  a_code_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.select_code != NoLamp |->
      result_o.lamp_states[scan_lamp(result_o.select_code)])
    else $error("select code names a dark lamp");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.select_code <= NoLamp)
    else $error("select code out of range");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && mode_q == MODE_OFF |=> lamps_q == '0)
    else $error("lamps lit after off tick");

  a_mode_change_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && mode_q != prev_mode_q |=> tick_q == '0)
    else $error("tick counter not cleared on mode change");

endmodule
